@@ design/assert_macros.svh @@
// Shared assertion helpers for the pin allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication check failed");
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define CHK_IMPLY(lbl, clk, rst_n, a, c)
`define CHK_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

@@ design/tbpa_pkg.sv @@
`timescale 1ns / 1ps
package tbpa_pkg;
  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_REMAP    = 3'd2,
    OP_VALIDATE = 3'd3,
    OP_FIND     = 3'd4,
    OP_LOAD_ENT = 3'd5,
    OP_LOAD_CNT = 3'd6
  } opcode_t;

  typedef enum logic [3:0] {
    ERR_NONE    = 4'd0,
    ERR_COUNT   = 4'd1,
    ERR_LIMIT   = 4'd2,
    ERR_SHARED  = 4'd3,
    ERR_INVALID = 4'd4,
    ERR_OWNED   = 4'd5,
    ERR_BANK    = 4'd6,
    ERR_FULL    = 4'd7,
    ERR_LAST    = 4'd8,
    ERR_INDEX   = 4'd9
  } err_t;

  localparam logic [6:0] PIN_NONE = 7'h7f;
  localparam logic [0:0] REG_MASK = 1'b0;
  localparam logic [0:0] REG_LIMIT = 1'b1;

  typedef struct packed {
    logic load;
    logic scan;
    logic walk;
    logic exec;
  } tbpa_cmd_t;

  typedef struct packed {
    logic needs_check;
    logic scan_done;
    logic walk_done;
  } tbpa_sts_t;
endpackage

@@ design/two_bank_pin_allocator_unit.sv @@
`timescale 1ns / 1ps
// Two-bank output pin allocator.
// Input channel in_valid/in_ready carries one command item (opcode, bank,
// slot index, pin number, new count); the output channel out_valid/out_ready
// returns one result item (ok, error code, result pin) per command.
// Checked commands (add, remove, remap, validate, find) first scan the pin
// space one pin per cycle, counting usable pins and finding the lowest free
// one, then walk the bank entries one per cycle; the walk stops early when
// the layout check fails. Load commands skip the scan and the walk. One
// command is in flight at a time; in_ready returns in the cycle the result
// reaches the output register, so the next item is taken while a result
// still waits. When out_ready is low the result holds; the following
// command runs its checks and waits only at the final step.
// Reset clears both banks to no pin, counts to zero, the mask to zero and the
// PWM limit to 8. The APB port writes the mask at 0x0 and the limit at 0x8.
module two_bank_pin_allocator_unit
  import tbpa_pkg::*;
#(
  parameter int BANK_SLOTS = 14,
  parameter int PIN_SPACE  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [1:0]  in_bank,
  input  logic [3:0]  in_slot_index,
  input  logic [6:0]  in_pin_number,
  input  logic [3:0]  in_new_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [3:0]  out_error_code,
  output logic [6:0]  out_result_pin,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  logic [63:0] mask_r;
  logic [3:0]  limit_r;
  tbpa_cmd_t   cmd;
  tbpa_sts_t   sts;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_LIMIT) ? {60'd0, limit_r} : mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= 64'd0;
      limit_r <= 4'd8;
    end else if (psel && penable && pwrite) begin
      if (paddr[3] == REG_MASK) mask_r <= pwdata;
      else limit_r <= pwdata[3:0];
    end
  end

  tbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tbpa_datapath #(
    .BANK_SLOTS (BANK_SLOTS),
    .PIN_SPACE  (PIN_SPACE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_bank        (in_bank),
    .in_slot_index  (in_slot_index),
    .in_pin_number  (in_pin_number),
    .in_new_count   (in_new_count),
    .valid_mask     (mask_r),
    .pwm_limit      (limit_r),
    .out_ok         (out_ok),
    .out_error_code (out_error_code),
    .out_result_pin (out_result_pin)
  );
endmodule

@@ design/tbpa_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tbpa_ctrl
  import tbpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  tbpa_sts_t sts,
  output tbpa_cmd_t cmd
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WALK, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.needs_check) begin
          state_nxt = S_EXEC;
        end else if (sts.scan_done) begin
          state_nxt = S_WALK;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CHK_NEXT(a_exec_shows, clk, rst_n, cmd.exec, out_valid_r)
  `CHK_IMPLY(a_no_overwrite, clk, rst_n, cmd.exec, !out_valid_r || out_ready)
  `CHK_NEXT(a_busy_after_load, clk, rst_n, cmd.load, !in_ready)
endmodule

@@ design/tbpa_datapath.sv @@
`timescale 1ns / 1ps
module tbpa_datapath
  import tbpa_pkg::*;
#(
  parameter int BANK_SLOTS = 14,
  parameter int PIN_SPACE  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tbpa_cmd_t   cmd,
  output tbpa_sts_t   sts,
  input  logic [2:0]  in_opcode,
  input  logic [1:0]  in_bank,
  input  logic [3:0]  in_slot_index,
  input  logic [6:0]  in_pin_number,
  input  logic [3:0]  in_new_count,
  input  logic [63:0] valid_mask,
  input  logic [3:0]  pwm_limit,
  output logic        out_ok,
  output logic [3:0]  out_error_code,
  output logic [6:0]  out_result_pin
);
  localparam int SLOT_W = (BANK_SLOTS > 1) ? $clog2(BANK_SLOTS) : 1;
  localparam int PIN_W  = $clog2(PIN_SPACE);
  localparam int SC_W   = PIN_W + 1;
  localparam int TOT_W  = $clog2(PIN_SPACE + 1);
  localparam logic [3:0] SLOTS4 = 4'(BANK_SLOTS);
  localparam logic [6:0] SPACE7 = 7'(PIN_SPACE);

  logic [6:0]       pwm_r [BANK_SLOTS];
  logic [6:0]       sw_r  [BANK_SLOTS];
  logic [3:0]       pcnt_r, scnt_r;
  logic [2:0]       op_r;
  logic [1:0]       bank_r;
  logic [3:0]       idx_r, ncnt_r;
  logic [6:0]       pin_r;
  logic [SC_W-1:0]  sc_r;
  logic [TOT_W-1:0] tot_r;
  logic [6:0]       free_r;
  logic             found_r;
  logic             wb_r;
  logic [3:0]       wi_r;
  logic [3:0]       cerr_r;
  logic [6:0]       cbad_r;
  logic             ok_r;
  logic [3:0]       err_r;
  logic [6:0]       rpin_r;

  logic [PIN_SPACE-1:0] umask;
  assign umask = valid_mask[PIN_SPACE-1:0];

  function automatic logic usable(input logic [6:0] pin);
    logic r;
    r = 1'b0;
    if (!pin[6] && ({1'b0, pin[5:0]} < SPACE7)) begin
      r = umask[pin[PIN_W-1:0]];
    end
    return r;
  endfunction

  function automatic logic owned(input logic [6:0] pin);
    logic r;
    r = 1'b0;
    for (int j = 0; j < BANK_SLOTS; j++) begin
      if ((4'(j) < pcnt_r) && (pwm_r[j] == pin)) r = 1'b1;
      if ((4'(j) < scnt_r) && (sw_r[j] == pin)) r = 1'b1;
    end
    return r;
  endfunction

  // shared entry read port
  logic [3:0] cnt_b, rd_addr;
  logic       rd_bank;
  logic [6:0] rd_pin;

  assign cnt_b   = bank_r[0] ? scnt_r : pcnt_r;
  assign rd_bank = cmd.walk ? wb_r : bank_r[0];
  assign rd_addr = cmd.walk ? wi_r : ((op_r == OP_REMOVE) ? (cnt_b - 4'd1) : idx_r);

  always_comb begin
    rd_pin = PIN_NONE;
    if (rd_addr < SLOTS4) begin
      rd_pin = rd_bank ? sw_r[rd_addr[SLOT_W-1:0]] : pwm_r[rd_addr[SLOT_W-1:0]];
    end
  end

  // layout walk
  logic [3:0] pre_err;
  logic       ent_ok, ent_dup, wlast;
  logic [3:0] wcnt;

  always_comb begin
    pre_err = ERR_NONE;
    if (pcnt_r < 4'd1 || pcnt_r > SLOTS4 || scnt_r < 4'd1 || scnt_r > SLOTS4) begin
      pre_err = ERR_COUNT;
    end else if (pcnt_r > pwm_limit) begin
      pre_err = ERR_LIMIT;
    end else if (8'({1'b0, pcnt_r} + {1'b0, scnt_r}) > 8'(tot_r)) begin
      pre_err = ERR_SHARED;
    end
    ent_ok  = usable(rd_pin);
    ent_dup = 1'b0;
    for (int j = 0; j < BANK_SLOTS; j++) begin
      if ((4'(j) < wi_r) && ((wb_r ? sw_r[j] : pwm_r[j]) == rd_pin)) ent_dup = 1'b1;
      if (wb_r && (4'(j) < pcnt_r) && (pwm_r[j] == rd_pin)) ent_dup = 1'b1;
    end
    wcnt  = wb_r ? scnt_r : pcnt_r;
    wlast = (wi_r + 4'd1) == wcnt;
  end

  assign sts.needs_check = (op_r <= OP_FIND);
  assign sts.scan_done   = (sc_r == SC_W'(PIN_SPACE));
  assign sts.walk_done   = (pre_err != ERR_NONE) || !ent_ok || ent_dup || (wlast && wb_r);

  // command execution
  logic             e_ok;
  logic [3:0]       e_err;
  logic [6:0]       e_rpin, add_pin;
  logic             wr_en, wr_bank;
  logic [SLOT_W-1:0] wr_addr;
  logic [6:0]       wr_data;
  logic             cnt_we, cnt_bank;
  logic [3:0]       cnt_val;

  assign add_pin = (pin_r == PIN_NONE) ? (found_r ? free_r : PIN_NONE) : pin_r;

  always_comb begin
    e_ok     = 1'b0;
    e_err    = ERR_NONE;
    e_rpin   = PIN_NONE;
    wr_en    = 1'b0;
    wr_bank  = bank_r[0];
    wr_addr  = idx_r[SLOT_W-1:0];
    wr_data  = pin_r;
    cnt_we   = 1'b0;
    cnt_bank = bank_r[0];
    cnt_val  = ncnt_r;
    if (op_r <= OP_FIND) begin
      if (cerr_r != ERR_NONE) begin
        e_err  = cerr_r;
        e_rpin = cbad_r;
      end else if (op_r == OP_VALIDATE) begin
        e_ok = 1'b1;
      end else if (op_r == OP_FIND) begin
        e_rpin = found_r ? free_r : PIN_NONE;
        if (found_r) e_ok = 1'b1;
        else e_err = ERR_SHARED;
      end else if (bank_r[1]) begin
        e_err  = ERR_BANK;
        e_rpin = (op_r == OP_REMAP) ? pin_r : PIN_NONE;
      end else if (op_r == OP_ADD) begin
        e_rpin = add_pin;
        if (cnt_b >= SLOTS4) begin
          e_err = ERR_FULL;
        end else if (8'({1'b0, pcnt_r} + {1'b0, scnt_r}) >= 8'(tot_r)) begin
          e_err = ERR_SHARED;
        end else if (!bank_r[0] && cnt_b >= pwm_limit) begin
          e_err = ERR_LIMIT;
        end else if (!usable(add_pin)) begin
          e_err = ERR_INVALID;
        end else if (owned(add_pin)) begin
          e_err = ERR_OWNED;
        end else begin
          e_ok    = 1'b1;
          wr_en   = 1'b1;
          wr_addr = cnt_b[SLOT_W-1:0];
          wr_data = add_pin;
          cnt_we  = 1'b1;
          cnt_val = cnt_b + 4'd1;
        end
      end else if (op_r == OP_REMOVE) begin
        if (cnt_b <= 4'd1) begin
          e_err = ERR_LAST;
        end else begin
          e_ok    = 1'b1;
          e_rpin  = rd_pin;
          wr_en   = 1'b1;
          wr_addr = rd_addr[SLOT_W-1:0];
          wr_data = PIN_NONE;
          cnt_we  = 1'b1;
          cnt_val = cnt_b - 4'd1;
        end
      end else begin
        e_rpin = pin_r;
        if (idx_r >= cnt_b) begin
          e_err = ERR_INDEX;
        end else if (!usable(pin_r)) begin
          e_err = ERR_INVALID;
        end else if (rd_pin == pin_r) begin
          e_ok = 1'b1;
        end else if (owned(pin_r)) begin
          e_err = ERR_OWNED;
        end else begin
          e_ok  = 1'b1;
          wr_en = 1'b1;
        end
      end
    end else if (op_r == OP_LOAD_ENT) begin
      if (bank_r[1]) begin
        e_err = ERR_BANK;
      end else if (idx_r >= SLOTS4) begin
        e_err  = ERR_INDEX;
        e_rpin = pin_r;
      end else begin
        e_ok   = 1'b1;
        e_rpin = pin_r;
        wr_en  = 1'b1;
      end
    end else if (op_r == OP_LOAD_CNT) begin
      if (bank_r[1]) begin
        e_err = ERR_BANK;
      end else begin
        e_ok   = 1'b1;
        cnt_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < BANK_SLOTS; j++) begin
        pwm_r[j] <= PIN_NONE;
        sw_r[j]  <= PIN_NONE;
      end
      pcnt_r <= 4'd0;
      scnt_r <= 4'd0;
    end else if (cmd.exec) begin
      if (wr_en) begin
        if (wr_bank) sw_r[wr_addr] <= wr_data;
        else pwm_r[wr_addr] <= wr_data;
      end
      if (cnt_we) begin
        if (cnt_bank) scnt_r <= cnt_val;
        else pcnt_r <= cnt_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      bank_r  <= in_bank;
      idx_r   <= in_slot_index;
      pin_r   <= in_pin_number;
      ncnt_r  <= in_new_count;
      sc_r    <= '0;
      tot_r   <= '0;
      free_r  <= PIN_NONE;
      found_r <= 1'b0;
      wb_r    <= 1'b0;
      wi_r    <= 4'd0;
      cerr_r  <= ERR_NONE;
      cbad_r  <= PIN_NONE;
    end
    if (cmd.scan && !sts.scan_done) begin
      sc_r <= sc_r + SC_W'(1);
      if (umask[sc_r[PIN_W-1:0]]) begin
        tot_r <= tot_r + TOT_W'(1);
        if (!found_r && !owned(7'(sc_r[PIN_W-1:0]))) begin
          free_r  <= 7'(sc_r[PIN_W-1:0]);
          found_r <= 1'b1;
        end
      end
    end
    if (cmd.walk) begin
      if (pre_err != ERR_NONE) begin
        cerr_r <= pre_err;
      end else if (!ent_ok) begin
        cerr_r <= ERR_INVALID;
        cbad_r <= rd_pin;
      end else if (ent_dup) begin
        cerr_r <= ERR_OWNED;
        cbad_r <= rd_pin;
      end else if (wlast) begin
        wb_r <= 1'b1;
        wi_r <= 4'd0;
      end else begin
        wi_r <= wi_r + 4'd1;
      end
    end
    if (cmd.exec) begin
      ok_r   <= e_ok;
      err_r  <= e_err;
      rpin_r <= e_rpin;
    end
  end

  assign out_ok         = ok_r;
  assign out_error_code = err_r;
  assign out_result_pin = rpin_r;
endmodule
